// File: rtl/rhsm_pkg.sv
package rhsm_pkg;

   // Field and register widths
   localparam int BYTE_W      = 8;
   localparam int PATTERN_W   = 64;
   localparam int LEN_W       = 4;
   localparam int BASE_W      = 8;
   localparam int MOD_W       = 16;
   localparam int HASH_W      = 16;
   localparam int COUNT_W     = 32;
   localparam int MATCH_POS_W = 32;
   localparam int PAT_IDX_W   = 3;

   // Remainder unit: 25-bit dividend padded to an even width, two bits per step
   localparam int DIV_W       = 26;
   localparam int MOD_STEPS   = DIV_W / 2;
   localparam int MOD_CNT_W   = 4;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Configuration port
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;

   localparam logic [PATTERN_W-1:0] RESET_PATTERN = '0;
   localparam logic [LEN_W-1:0]     RESET_LENGTH  = 4'd1;
   localparam logic [BASE_W-1:0]    RESET_BASE    = 8'd128;
   localparam logic [MOD_W-1:0]     RESET_MODULUS = 16'd37;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES,
      CSR_PATTERN_LENGTH,
      CSR_HASH_BASE,
      CSR_HASH_MODULUS
   } csr_index_type;

   typedef enum logic {
      ENTRY_CONTINUE,
      ENTRY_NEW_TEXT
   } entry_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              first;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic [HASH_W-1:0]      window_hash;
      logic                   hash_hit;
      logic                   match;
      logic [MATCH_POS_W-1:0] match_position;
      logic                   found_any;
   } rsp_payload_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]     pattern_length;
      logic [BASE_W-1:0]    hash_base;
      logic [MOD_W-1:0]     hash_modulus;
   } cfg_type;

   typedef struct packed {
      entry_kind_type    kind;
      logic [BYTE_W-1:0] text_byte;
      logic              last;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_out_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [MOD_W-1:0] modulus;
   } mod_req_type;

   typedef struct packed {
      logic             busy;
      logic [MOD_W-1:0] remainder;
   } mod_rsp_type;

endpackage

// File: rtl/rhsm_front.sv
module rhsm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rhsm_pkg::req_payload_type req_payload,
   output rhsm_pkg::queue_out_type   q_out,
   input  logic                      q_pop
);
   import rhsm_pkg::*;

   queue_entry_type    entries_ff [QUEUE_DEPTH];
   queue_entry_type    entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   queue_entry_type    new_entry;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   // Classify: a first byte opens a new text and reloads the configuration
   always_comb begin
      new_entry.kind      = req_payload.first ? ENTRY_NEW_TEXT : ENTRY_CONTINUE;
      new_entry.text_byte = req_payload.text_byte;
      new_entry.last      = req_payload.last;
   end

   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = new_entry;
         wr_ptr_in             = wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.entry = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/rhsm_mod.sv
module rhsm_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  rhsm_pkg::mod_req_type req,
   output rhsm_pkg::mod_rsp_type rsp
);
   import rhsm_pkg::*;

   logic                 busy_ff, busy_in;
   logic [MOD_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     shift_ff, shift_in;
   logic [MOD_W-1:0]     rem_ff, rem_in;
   logic [MOD_W:0]       try1, step1, try2, step2;

   // Two restoring steps per cycle, most significant dividend bits first
   always_comb begin
      try1  = {rem_ff, shift_ff[DIV_W-1]};
      step1 = (try1 >= {1'b0, req.modulus}) ? (try1 - {1'b0, req.modulus}) : try1;
      try2  = {step1[MOD_W-1:0], shift_ff[DIV_W-2]};
      step2 = (try2 >= {1'b0, req.modulus}) ? (try2 - {1'b0, req.modulus}) : try2;
   end

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         cnt_in   = MOD_CNT_W'(MOD_STEPS);
         shift_in = req.dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = step2[MOD_W-1:0];
         shift_in = {shift_ff[DIV_W-3:0], 2'b00};
         cnt_in   = cnt_ff - MOD_CNT_W'(1);
         if (cnt_ff == MOD_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   assign rsp.busy      = busy_ff;
   assign rsp.remainder = rem_ff;

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

// File: rtl/rhsm_back.sv
module rhsm_back #(
   parameter int PATTERN_MAX   = 8,
   parameter int POSITION_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rhsm_pkg::queue_out_type   q_out,
   output logic                      q_pop,
   input  rhsm_pkg::cfg_type         cfg,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rhsm_pkg::rsp_payload_type rsp_payload,
   output rhsm_pkg::mod_req_type     mod_req,
   input  rhsm_pkg::mod_rsp_type     mod_rsp
);
   import rhsm_pkg::*;

   localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int POS_W     = COUNT_W + 1;
   localparam logic [POS_W-1:0] POS_MAX = (POS_W'(1) << POSITION_BITS) - POS_W'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CFG_PH,
      S_CFG_PH_W,
      S_CFG_LP,
      S_CFG_LP_W,
      S_ROLL,
      S_ROLL_W,
      S_STEP,
      S_STEP_W,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [PATTERN_W-1:0]   act_pattern_ff, act_pattern_in;
   logic [LEN_W-1:0]       act_len_ff, act_len_in;
   logic [BASE_W-1:0]      act_base_ff, act_base_in;
   logic [MOD_W-1:0]       act_mod_ff, act_mod_in;
   logic [HASH_W-1:0]      lp_ff, lp_in;
   logic [HASH_W-1:0]      ph_ff, ph_in;
   logic [HASH_W-1:0]      rh_ff, rh_in;
   logic [COUNT_W-1:0]     seen_ff, seen_in;
   logic                   seen_match_ff, seen_match_in;
   logic [BYTE_W-1:0]      window_ff [PATTERN_MAX];
   logic [BYTE_W-1:0]      window_in [PATTERN_MAX];
   logic [PAT_IDX_W-1:0]   k_ff, k_in;
   logic [BYTE_W-1:0]      cur_byte_ff, cur_byte_in;
   logic                   cur_last_ff, cur_last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic [HASH_W-1:0]      mul_a;
   logic [BYTE_W-1:0]      mul_b;
   logic [BYTE_W-1:0]      mul_add;
   logic [HASH_W+BYTE_W-1:0] product;
   logic                   mod_start;
   logic [MOD_W:0]         unroll;
   logic [BYTE_W-1:0]      old_byte;
   logic                   full, hit, exact, all_eq;
   logic [POS_W-1:0]       pos_w;

   function automatic logic [BYTE_W-1:0] pat_char(input logic [PATTERN_W-1:0] pat,
                                                 input logic [PAT_IDX_W-1:0] idx);
      return pat[{idx, 3'b000} +: BYTE_W];
   endfunction

   // One shared multiplier; the remainder unit's shift register takes its product plus the added byte
   assign product          = mul_a * mul_b;
   assign mod_req.start    = mod_start;
   assign mod_req.dividend = DIV_W'(product) + DIV_W'(mul_add);
   assign mod_req.modulus  = act_mod_ff;

   assign old_byte = window_ff[WIN_IDX_W'(act_len_ff - LEN_W'(1))];

   // Window check against the pattern, newest byte against the last character
   always_comb begin
      logic [LEN_W-1:0] rev;
      all_eq = 1'b1;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         rev = act_len_ff - LEN_W'(j) - LEN_W'(1);
         if (LEN_W'(j) < act_len_ff) begin
            if (window_ff[j] != pat_char(act_pattern_ff, rev[PAT_IDX_W-1:0])) begin
               all_eq = 1'b0;
            end
         end
      end
   end

   always_comb begin
      full  = (seen_ff >= COUNT_W'(act_len_ff));
      hit   = full && (rh_ff == ph_ff);
      exact = hit && all_eq;
      pos_w = {1'b0, seen_ff} - POS_W'(act_len_ff) + POS_W'(1);
      if (pos_w > POS_MAX) begin
         pos_w = POS_MAX;
      end
   end

   always_comb begin
      state_in       = state_ff;
      act_pattern_in = act_pattern_ff;
      act_len_in     = act_len_ff;
      act_base_in    = act_base_ff;
      act_mod_in     = act_mod_ff;
      lp_in          = lp_ff;
      ph_in          = ph_ff;
      rh_in          = rh_ff;
      seen_in        = seen_ff;
      seen_match_in  = seen_match_ff;
      window_in      = window_ff;
      k_in           = k_ff;
      cur_byte_in    = cur_byte_ff;
      cur_last_in    = cur_last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      q_pop          = 1'b0;
      mod_start      = 1'b0;
      mul_a          = '0;
      mul_b          = '0;
      mul_add        = '0;
      unroll         = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop       = 1'b1;
               cur_byte_in = q_out.entry.text_byte;
               cur_last_in = q_out.entry.last;
               if (q_out.entry.kind == ENTRY_NEW_TEXT) begin
                  act_pattern_in = cfg.pattern_bytes;
                  act_base_in    = cfg.hash_base;
                  if (cfg.pattern_length == '0) begin
                     act_len_in = LEN_W'(1);
                  end else if (cfg.pattern_length > LEN_W'(PATTERN_MAX)) begin
                     act_len_in = LEN_W'(PATTERN_MAX);
                  end else begin
                     act_len_in = cfg.pattern_length;
                  end
                  act_mod_in    = (cfg.hash_modulus == '0) ? MOD_W'(1) : cfg.hash_modulus;
                  lp_in         = HASH_W'(1);
                  ph_in         = '0;
                  k_in          = '0;
                  rh_in         = '0;
                  seen_in       = '0;
                  seen_match_in = 1'b0;
                  for (int i = 0; i < PATTERN_MAX; i++) begin
                     window_in[i] = '0;
                  end
                  state_in = S_CFG_PH;
               end else begin
                  state_in = S_ROLL;
               end
            end
         end
         S_CFG_PH: begin
            mul_a     = ph_ff;
            mul_b     = act_base_ff;
            mul_add   = pat_char(act_pattern_ff, k_ff);
            mod_start = 1'b1;
            state_in  = S_CFG_PH_W;
         end
         S_CFG_PH_W: begin
            if (!mod_rsp.busy) begin
               ph_in = mod_rsp.remainder;
               if (k_ff != '0) begin
                  state_in = S_CFG_LP;
               end else if (LEN_W'(k_ff) + LEN_W'(1) == act_len_ff) begin
                  state_in = S_ROLL;
               end else begin
                  k_in     = k_ff + PAT_IDX_W'(1);
                  state_in = S_CFG_PH;
               end
            end
         end
         S_CFG_LP: begin
            mul_a     = lp_ff;
            mul_b     = act_base_ff;
            mod_start = 1'b1;
            state_in  = S_CFG_LP_W;
         end
         S_CFG_LP_W: begin
            if (!mod_rsp.busy) begin
               lp_in = mod_rsp.remainder;
               if (LEN_W'(k_ff) + LEN_W'(1) == act_len_ff) begin
                  state_in = S_ROLL;
               end else begin
                  k_in     = k_ff + PAT_IDX_W'(1);
                  state_in = S_CFG_PH;
               end
            end
         end
         S_ROLL: begin
            // Drop the oldest byte's weight once the window is full
            if (full) begin
               mul_a     = lp_ff;
               mul_b     = old_byte;
               mod_start = 1'b1;
               state_in  = S_ROLL_W;
            end else begin
               state_in = S_STEP;
            end
         end
         S_ROLL_W: begin
            if (!mod_rsp.busy) begin
               unroll = {1'b0, rh_ff} + {1'b0, act_mod_ff} - {1'b0, mod_rsp.remainder};
               if (unroll >= {1'b0, act_mod_ff}) begin
                  unroll = unroll - {1'b0, act_mod_ff};
               end
               rh_in    = unroll[HASH_W-1:0];
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            mul_a     = rh_ff;
            mul_b     = act_base_ff;
            mul_add   = cur_byte_ff;
            mod_start = 1'b1;
            state_in  = S_STEP_W;
         end
         S_STEP_W: begin
            if (!mod_rsp.busy) begin
               rh_in = mod_rsp.remainder;
               for (int i = PATTERN_MAX - 1; i > 0; i--) begin
                  window_in[i] = window_ff[i-1];
               end
               window_in[0] = cur_byte_ff;
               if (seen_ff != '1) begin
                  seen_in = seen_ff + COUNT_W'(1);
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.window_hash    = rh_ff;
               rsp_data_in.hash_hit       = hit;
               rsp_data_in.match          = exact;
               rsp_data_in.match_position = exact ? pos_w[MATCH_POS_W-1:0] : '0;
               rsp_data_in.found_any      = cur_last_ff && (seen_match_ff || exact);
               seen_match_in              = seen_match_ff || exact;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      cur_byte_ff <= cur_byte_in;
      cur_last_ff <= cur_last_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         act_pattern_ff <= RESET_PATTERN;
         act_len_ff     <= RESET_LENGTH;
         act_base_ff    <= RESET_BASE;
         act_mod_ff     <= RESET_MODULUS;
         lp_ff          <= HASH_W'(1);
         ph_ff          <= '0;
         rh_ff          <= '0;
         seen_ff        <= '0;
         seen_match_ff  <= 1'b0;
         k_ff           <= '0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < PATTERN_MAX; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         act_pattern_ff <= act_pattern_in;
         act_len_ff     <= act_len_in;
         act_base_ff    <= act_base_in;
         act_mod_ff     <= act_mod_in;
         lp_ff          <= lp_in;
         ph_ff          <= ph_in;
         rh_ff          <= rh_in;
         seen_ff        <= seen_in;
         seen_match_ff  <= seen_match_in;
         k_ff           <= k_in;
         rsp_valid_ff   <= rsp_valid_in;
         window_ff      <= window_in;
      end
   end

endmodule

// File: rtl/rolling_hash_substring_matcher_unit.sv
// Each byte takes one pass through the shared remainder unit while the window fills, two
//   once it is full; the unit reduces two dividend bits per cycle. The back end finishes
//   one byte before it takes the next; the queue holds waiting bytes meanwhile.
// A byte with first set first computes the pattern hash and power for the new pattern.
// Reset (synchronous, active high) empties the queue and result register, loads the
//   register defaults and clears the window, hash and counters.
module rolling_hash_substring_matcher_unit #(
   parameter int PATTERN_MAX   = 8,
   parameter int POSITION_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rhsm_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rhsm_pkg::rsp_payload_type              rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [rhsm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [rhsm_pkg::CSR_DATA_W-1:0]        csr_data
);
   import rhsm_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_out;
   logic          q_pop;
   mod_req_type   mod_req;
   mod_rsp_type   mod_rsp;

   // Configuration registers: written any time, picked up by the back end only
   // on the next transaction that opens a new text.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:  cfg_in.pattern_bytes  = csr_data[PATTERN_W-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_data[LEN_W-1:0];
            CSR_HASH_BASE:      cfg_in.hash_base      = csr_data[BASE_W-1:0];
            CSR_HASH_MODULUS:   cfg_in.hash_modulus   = csr_data[MOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes  <= RESET_PATTERN;
         cfg_ff.pattern_length <= RESET_LENGTH;
         cfg_ff.hash_base      <= RESET_BASE;
         cfg_ff.hash_modulus   <= RESET_MODULUS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify each transaction, park it in a two-entry queue
   rhsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_out       (q_out),
      .q_pop       (q_pop)
   );

   // Back: load the configuration on a new text, then sequence the hash update, window shift and match check per byte
   rhsm_back #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_out       (q_out),
      .q_pop       (q_pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .mod_req     (mod_req),
      .mod_rsp     (mod_rsp)
   );

   // Shared restoring remainder unit for every product reduction
   rhsm_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

endmodule

// File: rtl/rhsm_checker.sv
module rhsm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input rhsm_pkg::req_payload_type        req_payload,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input rhsm_pkg::rsp_payload_type        rsp_payload
);
   import rhsm_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_match_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.match |-> rsp_payload.hash_hit)
      else $error("match reported without hash hit");

   a_position_iff_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.match_position != '0) == rsp_payload.match))
      else $error("match position disagrees with match flag");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind rolling_hash_substring_matcher_unit rhsm_checker u_rhsm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_payload      (req_payload),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_payload      (rsp_payload)
);
